// ===== rtl/efnm_pkg.sv =====
`default_nettype none
package efnm_pkg;

  localparam int DEF_MAX_PIXELS     = 4096;
  localparam int DEF_MAX_COMPONENTS = 16;
  localparam int DEF_MAX_TRAIN      = 256;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_PIXELS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COMPONENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TRAIN      = 2'd2;

  localparam logic [1:0] CMD_MEAN   = 2'd0;
  localparam logic [1:0] CMD_WEIGHT = 2'd1;
  localparam logic [1:0] CMD_TRAIN  = 2'd2;
  localparam logic [1:0] CMD_PIXEL  = 2'd3;

  localparam logic [62:0] DIST_MAX = {63{1'b1}};

  typedef enum logic [1:0] {
    OP_MEAN,
    OP_WEIGHT,
    OP_TRAIN,
    OP_PIXEL
  } op_t;

  typedef struct packed {
    op_t                kind;
    logic [11:0]        pixel_index;
    logic [3:0]         component_index;
    logic [7:0]         train_index;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [12:0] num_pixels;
    logic [4:0]  num_components;
    logic [8:0]  num_train;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN,
    S_MAC,
    S_DIST,
    S_DONE
  } state_t;

  function automatic logic signed [31:0] to_projection(input logic signed [47:0] acc);
    logic signed [32:0] sh;
    begin
      sh = 33'(acc >>> 15);
      if (sh > 33'sh0_7FFF_FFFF) begin
        to_projection = 32'sh7FFF_FFFF;
      end else if (sh < -33'sh0_8000_0000) begin
        to_projection = 32'sh8000_0000;
      end else begin
        to_projection = sh[31:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/efnm_front.sv =====
`default_nettype none
module efnm_front import efnm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         cmd,
  input  wire logic [11:0]        pixel_index,
  input  wire logic [3:0]         component_index,
  input  wire logic [7:0]         train_index,
  input  wire logic signed [31:0] value,
  input  wire logic               last,
  output logic                    head_valid,
  output item_t                   head,
  input  wire logic               head_pop
);

  localparam int DEPTH = 4;

  item_t      q [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  item_t      item_in;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    case (cmd)
      CMD_MEAN:   item_in.kind = OP_MEAN;
      CMD_WEIGHT: item_in.kind = OP_WEIGHT;
      CMD_TRAIN:  item_in.kind = OP_TRAIN;
      CMD_PIXEL:  item_in.kind = OP_PIXEL;
      default:    item_in.kind = OP_PIXEL;
    endcase
    item_in.pixel_index     = pixel_index;
    item_in.component_index = component_index;
    item_in.train_index     = train_index;
    item_in.value           = value;
    item_in.last            = last;
  end

  assign full       = (count == 3'(DEPTH));
  assign head_valid = (count != 3'd0);
  assign head       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 3'd1;
        2'b01:   count <= count - 3'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/efnm_engine.sv =====
`default_nettype none
module efnm_engine import efnm_pkg::*; #(
  parameter int MAX_PIXELS     = DEF_MAX_PIXELS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_TRAIN      = DEF_MAX_TRAIN
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  head_valid,
  input  wire item_t head,
  output logic       head_pop,
  output logic       res_valid,
  input  wire logic  res_ready,
  output logic [7:0] res_index,
  output logic [62:0] res_distance
);

  localparam int PIX_AW = $clog2(MAX_PIXELS);
  localparam int W_AW   = $clog2(MAX_PIXELS * MAX_COMPONENTS);
  localparam int T_AW   = (MAX_TRAIN * MAX_COMPONENTS > 1) ?
                          $clog2(MAX_TRAIN * MAX_COMPONENTS) : 1;
  localparam int C_W    = $clog2(MAX_COMPONENTS + 1);
  localparam int C_IW   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int T_CW   = $clog2(MAX_TRAIN + 1);

  localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ACC_MIN = -49'sh0_8000_0000_0000;

  state_t state;
  state_t state_next;

  logic signed [15:0] mean_mem   [MAX_PIXELS];
  logic signed [15:0] weight_mem [MAX_PIXELS * MAX_COMPONENTS];
  logic signed [31:0] train_mem  [MAX_TRAIN * MAX_COMPONENTS];

  logic signed [15:0] mean_q;
  logic signed [15:0] weight_q;
  logic signed [31:0] train_q;

  logic signed [47:0] acc [MAX_COMPONENTS];

  logic [C_W-1:0]  ncomp;
  logic [T_CW-1:0] ntrain;

  logic [7:0]         gray;
  logic               cur_last;
  logic               pix_ok;
  logic [W_AW-1:0]    w_base;
  logic signed [17:0] norm;

  logic            mac_issue;
  logic [C_W-1:0]  ic;
  logic            v1;
  logic [C_IW-1:0] c1;
  logic            v2;
  logic [C_IW-1:0] c2;
  logic signed [33:0] prod;
  logic signed [48:0] acc_sum;

  logic            dist_issue;
  logic            dist_enter;
  logic [T_CW-1:0] dt;
  logic [C_W-1:0]  dc;
  logic            d1, d2, d3, d4;
  logic            f1, f2, f3;
  logic            l1, l2, l3;
  logic [T_CW-1:0] t1, t2, t3;
  logic [C_IW-1:0] k1;
  logic [31:0]     mag;
  logic [63:0]     sq;
  logic signed [32:0] diff;
  logic [62:0]     sq_sat;
  logic [63:0]     dsum;
  logic [62:0]     dsat;
  logic [62:0]     run_d;
  logic [62:0]     best_d;
  logic [T_CW-1:0] best_i;

  logic head_in_pix;
  logic head_in_comp;
  logic head_in_train;

  always_comb begin
    if (32'(cfg.num_components) > 32'(MAX_COMPONENTS)) begin
      ncomp = C_W'(MAX_COMPONENTS);
    end else begin
      ncomp = C_W'(cfg.num_components);
    end
    if (cfg.num_train == 9'd0) begin
      ntrain = T_CW'(1);
    end else if (32'(cfg.num_train) > 32'(MAX_TRAIN)) begin
      ntrain = T_CW'(MAX_TRAIN);
    end else begin
      ntrain = T_CW'(cfg.num_train);
    end
  end

  assign head_in_pix   = 32'(head.pixel_index) < 32'(MAX_PIXELS);
  assign head_in_comp  = 32'(head.component_index) < 32'(MAX_COMPONENTS);
  assign head_in_train = 32'(head.train_index) < 32'(MAX_TRAIN);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head_valid && head.kind == OP_PIXEL) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (pix_ok && ncomp != '0) begin
          state_next = S_MAC;
        end else if (cur_last) begin
          state_next = S_DIST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MAC: begin
        if (ic == ncomp && !v1 && !v2) begin
          state_next = cur_last ? S_DIST : S_IDLE;
        end
      end
      S_DIST: begin
        if ((ncomp == '0 || dt == ntrain) && !d1 && !d2 && !d3 && !d4) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    head_pop   = (state == S_IDLE) && head_valid;
    res_valid  = (state == S_DONE);
    mac_issue  = (state == S_MAC) && (ic != ncomp);
    dist_issue = (state == S_DIST) && (ncomp != '0) && (dt != ntrain);
    dist_enter = (state_next == S_DIST) && (state != S_DIST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (head_pop && head.kind == OP_MEAN && head_in_pix) begin
      mean_mem[PIX_AW'(head.pixel_index)] <= head.value[15:0];
    end
    mean_q <= mean_mem[PIX_AW'(head.pixel_index)];
  end

  always_ff @(posedge clk) begin
    if (head_pop && head.kind == OP_WEIGHT && head_in_pix && head_in_comp) begin
      weight_mem[W_AW'(32'(head.pixel_index) * MAX_COMPONENTS
                       + 32'(head.component_index))] <= head.value[15:0];
    end
    weight_q <= weight_mem[w_base + W_AW'(ic)];
  end

  always_ff @(posedge clk) begin
    if (head_pop && head.kind == OP_TRAIN && head_in_train && head_in_comp) begin
      train_mem[T_AW'(32'(head.train_index) * MAX_COMPONENTS
                      + 32'(head.component_index))] <= head.value;
    end
    train_q <= train_mem[T_AW'(32'(dt) * MAX_COMPONENTS + 32'(dc))];
  end

  // test pixel front half
  always_ff @(posedge clk) begin
    if (head_pop && head.kind == OP_PIXEL) begin
      gray     <= head.value[7:0];
      cur_last <= head.last;
      pix_ok   <= (32'(head.pixel_index) < 32'(cfg.num_pixels)) && head_in_pix;
      w_base   <= W_AW'(32'(head.pixel_index) * MAX_COMPONENTS);
    end
    if (state == S_MEAN) begin
      norm <= $signed({2'b00, gray, 8'h00}) - 18'(mean_q) + 18'sd256;
    end
  end

  // multiply-accumulate pipeline
  assign acc_sum = 49'(acc[c2]) + 49'(prod);

  always_ff @(posedge clk) begin
    prod <= norm * weight_q;
    c1   <= C_IW'(ic);
    c2   <= c1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (state == S_MEAN) begin
        ic <= '0;
      end else if (mac_issue) begin
        ic <= ic + C_W'(1);
      end
      v1 <= mac_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        acc[i] <= '0;
      end
    end else if (state == S_DONE && res_ready) begin
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        acc[i] <= '0;
      end
    end else if (v2) begin
      if (acc_sum > ACC_MAX) begin
        acc[c2] <= ACC_MAX[47:0];
      end else if (acc_sum < ACC_MIN) begin
        acc[c2] <= ACC_MIN[47:0];
      end else begin
        acc[c2] <= acc_sum[47:0];
      end
    end
  end

  // distance pipeline
  assign diff   = 33'(train_q) - 33'(to_projection(acc[k1]));
  assign sq_sat = sq[63] ? DIST_MAX : sq[62:0];
  assign dsum   = {1'b0, (f3 ? 63'd0 : run_d)} + {1'b0, sq_sat};
  assign dsat   = dsum[63] ? DIST_MAX : dsum[62:0];

  always_ff @(posedge clk) begin
    k1  <= C_IW'(dc);
    f1  <= (dc == '0);
    l1  <= (dc == ncomp - C_W'(1));
    t1  <= dt;
    mag <= diff[32] ? 32'(-diff) : diff[31:0];
    f2  <= f1;
    l2  <= l1;
    t2  <= t1;
    sq  <= 64'(mag) * 64'(mag);
    f3  <= f2;
    l3  <= l2;
    t3  <= t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dt <= '0;
      dc <= '0;
      d1 <= 1'b0;
      d2 <= 1'b0;
      d3 <= 1'b0;
      d4 <= 1'b0;
    end else begin
      if (dist_enter) begin
        dt <= '0;
        dc <= '0;
      end else if (dist_issue) begin
        if (dc == ncomp - C_W'(1)) begin
          dc <= '0;
          dt <= dt + T_CW'(1);
        end else begin
          dc <= dc + C_W'(1);
        end
      end
      d1 <= dist_issue;
      d2 <= d1;
      d3 <= d2;
      d4 <= d3;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_enter) begin
      best_d <= '0;
      best_i <= '0;
    end else if (d3) begin
      run_d <= dsat;
      if (l3 && (t3 == '0 || dsat < best_d)) begin
        best_d <= dsat;
        best_i <= t3;
      end
    end
  end

  assign res_index    = 8'(best_i);
  assign res_distance = best_d;

endmodule
`default_nettype wire

// ===== rtl/eigenface_nearest_match_core.sv =====
// Eigenface nearest-match engine.
// Input channel (push/full): load items write the mean image, the eigenface
// weights and the training projections; test pixels (cmd 3) stream in and
// are projected onto the components. A test pixel with last set finishes
// the image and produces one result; all other items produce none.
// Result channel (empty/pop): best_index and best_distance of the first
// training image with the smallest squared distance.
// Config (cfg_valid/cfg_ready, always ready): num_pixels, num_components,
// num_train; the user must write them only while the block is idle (unenforced).
// Items pass a 4-entry input queue, so transfers continue while the engine
// works; loads are stored as the engine pops them while idle. A test pixel
// runs through the single multiply-accumulate unit, one component after
// another via its weight memory port. The final pixel adds a distance pass,
// one distance term per cycle through the training memory port.
// Reset clears control state and the accumulators; stores hold garbage
// until written and get no clearing pass. One result is held at the output;
// if it is not popped, the next result waits and the input queue fills.
`default_nettype none
module eigenface_nearest_match_core import efnm_pkg::*; #(
  parameter int MAX_PIXELS     = DEF_MAX_PIXELS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_TRAIN      = DEF_MAX_TRAIN
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [1:0]            cmd,
  input  wire logic [11:0]           pixel_index,
  input  wire logic [3:0]            component_index,
  input  wire logic [7:0]            train_index,
  input  wire logic signed [31:0]    value,
  input  wire logic                  last,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 best_index,
  output logic [62:0]                best_distance,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        head_valid;
  item_t       head;
  logic        head_pop;
  logic        res_valid;
  logic        res_ready;
  logic [7:0]  res_index;
  logic [62:0] res_distance;
  logic        out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_pixels     <= 13'd4096;
      cfg.num_components <= 5'd16;
      cfg.num_train      <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_PIXELS:     cfg.num_pixels     <= cfg_data[12:0];
        REG_NUM_COMPONENTS: cfg.num_components <= cfg_data[4:0];
        REG_NUM_TRAIN:      cfg.num_train      <= cfg_data[8:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  efnm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .cmd             (cmd),
    .pixel_index     (pixel_index),
    .component_index (component_index),
    .train_index     (train_index),
    .value           (value),
    .last            (last),
    .head_valid      (head_valid),
    .head            (head),
    .head_pop        (head_pop)
  );

  efnm_engine #(
    .MAX_PIXELS     (MAX_PIXELS),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_TRAIN      (MAX_TRAIN)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_index    (res_index),
    .res_distance (res_distance)
  );

  assign res_ready = !out_valid;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      best_index    <= res_index;
      best_distance <= res_distance;
    end
  end

endmodule
`default_nettype wire
